// File: rtl/dnn_pkg.sv
package dnn_pkg;

  // Fixed field widths of the item and result ports.
  localparam int unsigned IdxBits   = 3;
  localparam int unsigned PosBits   = 16;
  localparam int unsigned DistBits  = 17;
  localparam int unsigned DirBits   = 2;

  // Reset value of the distance limit register.
  localparam logic [DistBits-1:0] MaxDistReset = 17'd1000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [DirBits-1:0] {
    DIR_EAST  = 2'd0,
    DIR_WEST  = 2'd1,
    DIR_NORTH = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REF,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // write the item's position into the table
    logic start;     // capture the query and clear the search state
    logic ref_load;  // capture the reference position
    logic scan_step; // score one candidate and advance
  } dnn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ref_ok;    // reference index lies inside the table
    logic scan_last; // the candidate being scored is the last one
  } dnn_status_t;

endpackage

// File: rtl/dnn_ctrl.sv
module dnn_ctrl
  import dnn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        cmd_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output dnn_cmd_t    cmd_o,
  input  dnn_status_t status_i
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_e'(cmd_i) == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_REF;
          end
        end
      end
      ST_REF: begin
        cmd_o.ref_load = 1'b1;
        state_d        = status_i.ref_ok ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dnn_datapath.sv
module dnn_datapath
  import dnn_pkg::*;
#(
  parameter int unsigned NUM_ELEMENTS = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dnn_cmd_t            cmd_i,
  output dnn_status_t         status_o,
  input  logic [IdxBits-1:0]  elem_index_i,
  input  logic [PosBits-1:0]  pos_x_i,
  input  logic [PosBits-1:0]  pos_y_i,
  input  logic [DirBits-1:0]  direction_i,
  input  logic                cfg_we_i,
  input  logic [DistBits-1:0] cfg_wdata_i,
  output logic [IdxBits-1:0]  nearest_index_o,
  output logic                found_o,
  output logic [DistBits-1:0] best_score_o
);

  // Only indexes reachable by a load need storage; the rest read as zero.
  localparam int unsigned MaxIdx = 1 << IdxBits;
  localparam int unsigned Depth  = (NUM_ELEMENTS < MaxIdx) ? NUM_ELEMENTS : MaxIdx;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned IW     = $clog2(NUM_ELEMENTS);
  localparam int unsigned RW     = ((IW > IdxBits) ? IW : IdxBits) + 1;
  localparam int unsigned DW     = COORD_BITS + 1;
  localparam int unsigned ScW    = COORD_BITS + 2;
  localparam int unsigned CmpW   = (ScW > DistBits) ? ScW : DistBits;

  logic [COORD_BITS-1:0] x_q [Depth];
  logic [COORD_BITS-1:0] y_q [Depth];
  logic [DistBits-1:0]   max_dist_q;
  logic [IdxBits-1:0]    ref_q;
  logic [DirBits-1:0]    dir_q;
  logic [COORD_BITS-1:0] rx_q, ry_q;
  logic [IW-1:0]         cnt_q, chosen_q;
  logic [DistBits-1:0]   best_q;
  logic                  found_q;

  logic                  wr_ok;
  logic [31:0]           ext_x, ext_y;
  logic [RW-1:0]         rd_idx;
  logic                  rd_in_range;
  logic [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [DW-1:0]  dx, dy, along, across;
  logic                  ok;
  logic [DW-1:0]         across_abs;
  logic [ScW-1:0]        score;
  logic                  skip, better;

  // Load path: wrap the 16-bit position to the coordinate width.
  assign ext_x = 32'(signed'(pos_x_i));
  assign ext_y = 32'(signed'(pos_y_i));
  assign wr_ok = (RW'(elem_index_i) < RW'(Depth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        x_q[i] <= '0;
        y_q[i] <= '0;
      end
    end else if (cmd_i.load && wr_ok) begin
      x_q[elem_index_i[AW-1:0]] <= ext_x[COORD_BITS-1:0];
      y_q[elem_index_i[AW-1:0]] <= ext_y[COORD_BITS-1:0];
    end
  end

  // Distance limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MaxDistReset;
    end else if (cfg_we_i) begin
      max_dist_q <= cfg_wdata_i;
    end
  end

  // Single table read port: reference during capture, candidate during scan.
  assign rd_idx      = cmd_i.ref_load ? RW'(ref_q) : RW'(cnt_q);
  assign rd_in_range = (rd_idx < RW'(Depth));
  assign rd_x        = rd_in_range ? x_q[rd_idx[AW-1:0]] : '0;
  assign rd_y        = rd_in_range ? y_q[rd_idx[AW-1:0]] : '0;

  // Offsets of the candidate from the reference.
  assign dx = signed'({rd_x[COORD_BITS-1], rd_x}) - signed'({rx_q[COORD_BITS-1], rx_q});
  assign dy = signed'({rd_y[COORD_BITS-1], rd_y}) - signed'({ry_q[COORD_BITS-1], ry_q});

  // Pick the axis along the direction and check the candidate lies ahead.
  always_comb begin
    case (dir_e'(dir_q))
      DIR_EAST: begin
        along  = dx;
        across = dy;
        ok     = (along > 0);
      end
      DIR_WEST: begin
        along  = -dx;
        across = dy;
        ok     = (along > 0);
      end
      DIR_NORTH: begin
        along  = dy;
        across = dx;
        ok     = (along >= 0);
      end
      DIR_SOUTH: begin
        along  = -dy;
        across = dx;
        ok     = (along >= 0);
      end
      default: begin
        along  = dx;
        across = dy;
        ok     = 1'b0;
      end
    endcase
  end

  // Score and compare against the running best.
  assign across_abs = across[DW-1] ? DW'(-across) : DW'(across);
  assign score      = ScW'(unsigned'(along)) + ScW'(across_abs);
  assign skip       = (RW'(cnt_q) == RW'(ref_q));
  assign better     = ok && !skip && (CmpW'(score) < CmpW'(best_q));

  // Query and search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      dir_q    <= '0;
      rx_q     <= '0;
      ry_q     <= '0;
      cnt_q    <= '0;
      chosen_q <= '0;
      best_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ref_q   <= elem_index_i;
        dir_q   <= direction_i;
        cnt_q   <= '0;
        best_q  <= max_dist_q;
        found_q <= 1'b0;
      end
      if (cmd_i.ref_load) begin
        rx_q <= rd_x;
        ry_q <= rd_y;
      end
      if (cmd_i.scan_step) begin
        cnt_q <= cnt_q + 1'b1;
        if (better) begin
          best_q   <= DistBits'(score);
          chosen_q <= cnt_q;
          found_q  <= 1'b1;
        end
      end
    end
  end

  assign status_o.ref_ok    = (RW'(ref_q) < RW'(NUM_ELEMENTS));
  assign status_o.scan_last = (RW'(cnt_q) == RW'(NUM_ELEMENTS - 1));

  // Result fields, held steady until the result is taken.
  assign nearest_index_o = found_q ? IdxBits'(chosen_q) : ref_q;
  assign found_o         = found_q;
  assign best_score_o    = best_q;

endmodule

// File: rtl/directional_nearest_neighbor_core.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+------------------------------------------
// in       | in_valid_i / in_stall_o     | cmd_i, elem_index_i, pos_x_i, pos_y_i,
//          |                             | direction_i
// out      | out_valid_o / out_stall_i   | nearest_index_o, found_o, best_score_o
// cfg      | cfg_we_i                    | cfg_wdata_i (max distance)
//
// After a load item the next item may follow at once. A query first reads the
// reference position, then scores one candidate per cycle through the single
// table read port and raises out_valid_o when the last one is done; a reference
// index outside the table skips the scan. The result then holds until it is
// taken, and the input reopens in the cycle after that. Reset clears the
// position table to zero and the distance limit to 1000.
module directional_nearest_neighbor_core
  import dnn_pkg::*;
#(
  parameter int unsigned NUM_ELEMENTS = 8,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [IdxBits-1:0]  elem_index_i,
  input  logic [PosBits-1:0]  pos_x_i,
  input  logic [PosBits-1:0]  pos_y_i,
  input  logic [DirBits-1:0]  direction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IdxBits-1:0]  nearest_index_o,
  output logic                found_o,
  output logic [DistBits-1:0] best_score_o,
  input  logic                cfg_we_i,
  input  logic [DistBits-1:0] cfg_wdata_i
);

  dnn_cmd_t    cmd;
  dnn_status_t status;

  // Sequencer for loads and query scans.
  dnn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Position table, scorer and result registers.
  dnn_datapath #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .elem_index_i    (elem_index_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .direction_i     (direction_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .nearest_index_o (nearest_index_o),
    .found_o         (found_o),
    .best_score_o    (best_score_o)
  );

endmodule

// File: tb/directional_nearest_neighbor_core_test.sv
`timescale 1ns / 1ps

module directional_nearest_neighbor_core_test;
  import dnn_pkg::*;

  localparam int unsigned NumElements = 8;
  localparam int unsigned ScanCycles  = NumElements + 2;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned DrainGuard  = 50000;

  typedef struct {
    cmd_e               cmd;
    logic [IdxBits-1:0] idx;
    logic [PosBits-1:0] pos_x;
    logic [PosBits-1:0] pos_y;
    dir_e               dir;
  } nav_item_t;

  typedef struct {
    logic [IdxBits-1:0]  index;
    logic                found;
    logic [DistBits-1:0] score;
  } hit_t;

  // Block ports.
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                cmd_i;
  logic [IdxBits-1:0]  elem_index_i;
  logic [PosBits-1:0]  pos_x_i;
  logic [PosBits-1:0]  pos_y_i;
  logic [DirBits-1:0]  direction_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [IdxBits-1:0]  nearest_index_o;
  logic                found_o;
  logic [DistBits-1:0] best_score_o;
  logic                cfg_we_i;
  logic [DistBits-1:0] cfg_wdata_i;

  // Shadow copy of the position table and the distance limit.
  logic signed [PosBits-1:0] x_table [NumElements];
  logic signed [PosBits-1:0] y_table [NumElements];
  logic [DistBits-1:0]       dist_limit;

  nav_item_t pending_items [$];
  hit_t      expected_hits [$];
  nav_item_t on_bus;
  hit_t      want;
  bit        item_taken;
  int        items_queued;
  int        items_accepted;
  int        fail_count;

  // Sender burst state and receiver stall state.
  int burst_left;
  int gap_left;
  int stall_mode;
  int mode_left;
  int hold_left;
  bit pressure_done;
  bit next_stall;

  directional_nearest_neighbor_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .elem_index_i   (elem_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .direction_i    (direction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .nearest_index_o(nearest_index_o),
    .found_o        (found_o),
    .best_score_o   (best_score_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Scan every other element in index order and keep the first one that beats
  // the running best, which starts at the distance limit.
  function automatic hit_t search_nearest(input logic [IdxBits-1:0] ref_idx, input dir_e dir);
    int   rx, ry, cx, cy, along, across, best;
    bit   ok;
    hit_t hit;
    rx        = x_table[ref_idx];
    ry        = y_table[ref_idx];
    best      = int'(dist_limit);
    hit.index = ref_idx;
    hit.found = 1'b0;
    for (int i = 0; i < NumElements; i++) begin
      if (i == ref_idx) continue;
      cx = x_table[i];
      cy = y_table[i];
      case (dir)
        DIR_EAST: begin
          along  = cx - rx;
          across = cy - ry;
          ok     = along > 0;
        end
        DIR_WEST: begin
          along  = rx - cx;
          across = cy - ry;
          ok     = along > 0;
        end
        DIR_NORTH: begin
          along  = cy - ry;
          across = cx - rx;
          ok     = along >= 0;
        end
        default: begin
          along  = ry - cy;
          across = cx - rx;
          ok     = along >= 0;
        end
      endcase
      if (across < 0) across = -across;
      if (ok && (along + across < best)) begin
        best      = along + across;
        hit.index = IdxBits'(i);
        hit.found = 1'b1;
      end
    end
    hit.score = best[DistBits-1:0];
    return hit;
  endfunction

  // Mostly small clustered coordinates so that scores land under the limit,
  // with some wide, extreme and fully random values mixed in.
  function automatic logic [PosBits-1:0] random_coord();
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
      2, 3:    v = int'($urandom_range(0, 4000)) - 2000;
      default: v = int'($urandom_range(0, 120)) - 60;
    endcase
    return v[PosBits-1:0];
  endfunction

  task automatic queue_item(input nav_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic add_load(input int idx, input int x, input int y);
    nav_item_t it;
    it.cmd   = CMD_LOAD;
    it.idx   = IdxBits'(idx);
    it.pos_x = x[PosBits-1:0];
    it.pos_y = y[PosBits-1:0];
    it.dir   = dir_e'($urandom_range(0, 3));
    queue_item(it);
  endtask

  task automatic add_query(input int idx, input dir_e dir);
    nav_item_t it;
    it.cmd   = CMD_QUERY;
    it.idx   = IdxBits'(idx);
    it.pos_x = PosBits'($urandom);
    it.pos_y = PosBits'($urandom);
    it.dir   = dir;
    queue_item(it);
  endtask

  task automatic add_random_item();
    nav_item_t it;
    it.cmd   = ($urandom_range(0, 99) < 45) ? CMD_LOAD : CMD_QUERY;
    it.idx   = IdxBits'($urandom_range(0, NumElements - 1));
    it.pos_x = random_coord();
    it.pos_y = random_coord();
    it.dir   = dir_e'($urandom_range(0, 3));
    queue_item(it);
  endtask

  // The limit register is only written while nothing is in flight.
  task automatic set_limit(input logic [DistBits-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    dist_limit = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued item is taken and every result has arrived, then
  // give the block time to finish any trailing work.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((items_accepted != items_queued || expected_hits.size() != 0) &&
           guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * ScanCycles) @(posedge clk_i);
  endtask

  task automatic report_failure(input string what, input hit_t exp_hit);
    fail_count++;
    if (fail_count <= MaxReports) begin
      $display("%0t: %s: expected index %0d found %0d score %0d, got index %0d found %0d score %0d",
               $time, what, exp_hit.index, exp_hit.found, exp_hit.score,
               nearest_index_o, found_o, best_score_o);
    end
  endtask

  // Take note of each accepted item and update the shadow state.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      item_taken = 1'b1;
      items_accepted++;
      if (on_bus.cmd == CMD_LOAD) begin
        x_table[on_bus.idx] = on_bus.pos_x;
        y_table[on_bus.idx] = on_bus.pos_y;
      end else begin
        expected_hits.push_back(search_nearest(on_bus.idx, on_bus.dir));
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        want = '{default: '0};
        report_failure("result with no query pending", want);
      end else begin
        want = expected_hits.pop_front();
        if (nearest_index_o !== want.index || found_o !== want.found ||
            best_score_o !== want.score) begin
          report_failure("result mismatch", want);
        end
      end
    end
  end

  // Drive items in bursts of random length with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        on_bus = pending_items.pop_front();
        cmd_i        <= on_bus.cmd;
        elem_index_i <= on_bus.idx;
        pos_x_i      <= on_bus.pos_x;
        pos_y_i      <= on_bus.pos_y;
        direction_i  <= on_bus.dir;
        in_valid_i   <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(15, 40);
            default:    gap_left = $urandom_range(1, 5);
          endcase
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern. Once, mid run, it holds off for a long stretch so
  // the block fills up and stalls its input.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (!pressure_done && items_accepted >= 300) begin
      pressure_done = 1'b1;
      hold_left     = 400;
      next_stall    = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        0:       next_stall = 1'b0;
        1:       next_stall = ($urandom_range(0, 3) == 0);
        2:       next_stall = ($urandom_range(0, 3) != 0);
        default: next_stall = !out_stall_i;
      endcase
    end
    out_stall_i <= next_stall;
  end

  // Main sequence: directed items, then random phases under several limits.
  initial begin
    int unsigned phase_limits [$];
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = 1'b0;
    elem_index_i = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    direction_i  = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    for (int i = 0; i < NumElements; i++) begin
      x_table[i] = '0;
      y_table[i] = '0;
    end
    dist_limit     = MaxDistReset;
    item_taken     = 1'b0;
    items_queued   = 0;
    items_accepted = 0;
    fail_count     = 0;
    burst_left     = 1;
    gap_left       = 0;
    stall_mode     = 0;
    mode_left      = 0;
    hold_left      = 0;
    pressure_done  = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // With the cleared table every element sits on the reference, so north
    // takes the lowest other index at score zero and east finds nothing.
    add_query(3, DIR_NORTH);
    add_query(0, DIR_EAST);
    add_load(0, -32768, -32768);
    add_load(7, 32767, 32767);
    add_load(1, 0, 0);
    add_load(2, 5, 3);
    add_load(3, 5, -3);
    add_load(4, -4, 0);
    add_load(5, 0, -7);
    add_load(6, 0, 7);
    // Equal scores to the east: the lower index must win.
    add_query(1, DIR_EAST);
    add_query(1, DIR_WEST);
    add_query(1, DIR_NORTH);
    add_query(1, DIR_SOUTH);
    // Corners are out of reach under the reset limit.
    add_query(0, DIR_EAST);
    add_query(7, DIR_SOUTH);
    wait_idle();

    // Largest limit: scores across the whole coordinate range qualify.
    set_limit(17'h1FFFF);
    add_query(0, DIR_EAST);
    add_query(0, DIR_NORTH);
    add_query(7, DIR_WEST);
    add_query(7, DIR_SOUTH);
    add_query(7, DIR_EAST);
    add_load(7, -32768, 32767);
    add_query(0, DIR_NORTH);
    wait_idle();

    phase_limits = '{0, 1, 131071, 1000, 50, 65535};
    phase_limits.push_back($urandom_range(0, 131071));
    foreach (phase_limits[p]) begin
      set_limit(phase_limits[p][DistBits-1:0]);
      repeat (PhaseItems) add_random_item();
      wait_idle();
    end

    if (expected_hits.size() != 0) begin
      fail_count += expected_hits.size();
      $display("%0t: %0d expected results never arrived", $time, expected_hits.size());
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/dnn_pkg.sv
rtl/dnn_ctrl.sv
rtl/dnn_datapath.sv
rtl/directional_nearest_neighbor_core.sv
tb/directional_nearest_neighbor_core_test.sv
